### design/eod_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package eod_pkg;

    localparam int WINDOW  = 512;
    localparam int WIN_AW  = $clog2(WINDOW);
    localparam int SMP_W   = 16;
    localparam int SQ_W    = 31;
    localparam int SUM_W   = SQ_W + WIN_AW;
    localparam int THR_W   = 31;
    localparam int HOP_W   = 10;
    localparam int CNT_W   = 16;
    localparam int CFG_W   = 31;
    localparam int CFG_IW  = 2;

    typedef enum logic [CFG_IW-1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_HOP_LENGTH = 2'd1,
        REG_REFRACTORY = 2'd2,
        REG_PULSE      = 2'd3
    } cfg_reg_t;

    localparam logic [THR_W-1:0] THRESHOLD_RST  = 31'd53687091;
    localparam logic [HOP_W-1:0] HOP_LENGTH_RST = 10'd256;
    localparam logic [CNT_W-1:0] REFRACTORY_RST = 16'd86;
    localparam logic [CNT_W-1:0] PULSE_RST      = 16'd9;

    typedef struct packed {
        logic            hop;
        logic [SQ_W-1:0] new_sq;
        logic [SQ_W-1:0] old_sq;
    } stage_t;

    typedef struct packed {
        logic             marker_pulse;
        logic [THR_W-1:0] mean_energy;
        logic             onset;
        logic             hop_done;
    } result_t;

    function automatic logic [SQ_W-1:0] square_of(input logic signed [SMP_W-1:0] v);
        logic signed [2*SMP_W-1:0] prod;
        prod = v * v;
        return prod[SQ_W-1:0];
    endfunction

endpackage

`default_nettype wire

### design/eod_window.sv
`timescale 1ns / 1ps
`default_nettype none

module eod_window
    import eod_pkg::*;
(
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    wr_en,
    input  wire logic signed [SMP_W-1:0] wr_data,
    output logic signed [SMP_W-1:0]      old_sample
);

    logic [SMP_W-1:0]  mem [WINDOW];
    logic [WIN_AW-1:0] wp_reg;
    logic [WIN_AW-1:0] wp_next;
    logic              filled_reg;
    logic [SMP_W-1:0]  rd_data_reg;
    logic              wrap;

    assign wrap = (wp_reg == WIN_AW'(WINDOW - 1));

    always_comb begin
        wp_next = wp_reg;
        if (wr_en) begin
            wp_next = wrap ? '0 : wp_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg     <= '0;
            filled_reg <= 1'b0;
        end else begin
            wp_reg <= wp_next;
            if (wr_en && wrap) begin
                filled_reg <= 1'b1;
            end
        end
    end

    // read of the next slot never collides with the write of the current one
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wp_reg] <= wr_data;
        end
        rd_data_reg <= mem[wp_next];
    end

    // slots not yet written on the first pass read as zero
    assign old_sample = filled_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

### design/eod_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module eod_eval
    import eod_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             load,
    input  wire stage_t           stage,
    input  wire logic [THR_W-1:0] energy_threshold,
    input  wire logic [CNT_W-1:0] refractory_hops,
    input  wire logic [CNT_W-1:0] pulse_hops,
    output result_t               result
);

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] refr_reg;
    logic [CNT_W-1:0] refr_next;
    logic [CNT_W-1:0] pulse_reg;
    logic [CNT_W-1:0] pulse_next;
    logic             pin_reg;
    logic             pin_next;
    logic [THR_W-1:0] mean;
    logic             onset;
    logic [CNT_W-1:0] refr_load;
    logic [CNT_W-1:0] pulse_load;
    logic [SUM_W-1:0] mean_wide;
    result_t          result_reg;
    result_t          result_next;

    always_comb begin
        sum_next  = sum_reg + SUM_W'(stage.new_sq) - SUM_W'(stage.old_sq);
        mean_wide = sum_next / WINDOW;
        mean      = mean_wide[THR_W-1:0];
        onset     = stage.hop && (mean >= energy_threshold) && (refr_reg == '0);

        refr_load  = onset ? refractory_hops : refr_reg;
        pulse_load = onset ? pulse_hops : pulse_reg;

        refr_next  = refr_reg;
        pulse_next = pulse_reg;
        pin_next   = pin_reg;
        if (stage.hop) begin
            refr_next  = (refr_load != '0) ? refr_load - 1'b1 : '0;
            pulse_next = (pulse_load != '0) ? pulse_load - 1'b1 : '0;
            pin_next   = (pulse_next != '0);
        end

        result_next.hop_done     = stage.hop;
        result_next.onset        = onset;
        result_next.mean_energy  = stage.hop ? mean : '0;
        result_next.marker_pulse = pin_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            refr_reg  <= '0;
            pulse_reg <= '0;
            pin_reg   <= 1'b0;
        end else if (load) begin
            sum_reg   <= sum_next;
            refr_reg  <= refr_next;
            pulse_reg <= pulse_next;
            pin_reg   <= pin_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

### design/energy_onset_detector.sv
// a result word is registered in stage_reg, then in the eval result register, after its sample word is accepted
// throughput: one word per cycle while m_tready does not stall the pipeline, set by the running sum update
// s_tready drops only when both pipeline stages hold words and m_tready is low
// aresetn is synchronous, active low: config returns to defaults, sum and counters clear
// window slots read as zero until the first full pass writes them, so no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module energy_onset_detector
    import eod_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [15:0]       s_tdata,   // sample
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [39:0]            m_tdata,   // onset, mean_energy, marker_pulse, zero pad
    output logic                   m_tuser    // hop_done
);

    logic [THR_W-1:0] thr_reg;
    logic [HOP_W-1:0] hop_len_reg;
    logic [CNT_W-1:0] refr_hops_reg;
    logic [CNT_W-1:0] pulse_hops_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg        <= THRESHOLD_RST;
            hop_len_reg    <= HOP_LENGTH_RST;
            refr_hops_reg  <= REFRACTORY_RST;
            pulse_hops_reg <= PULSE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD:  thr_reg        <= cfg_wdata[THR_W-1:0];
                REG_HOP_LENGTH: hop_len_reg    <= cfg_wdata[HOP_W-1:0];
                REG_REFRACTORY: refr_hops_reg  <= cfg_wdata[CNT_W-1:0];
                REG_PULSE:      pulse_hops_reg <= cfg_wdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic a_valid_reg;
    logic m_valid_reg;
    logic adv_b;
    logic adv_a;
    logic accept;

    assign adv_b    = !m_valid_reg || m_tready;
    assign adv_a    = !a_valid_reg || adv_b;
    assign s_tready = adv_a;
    assign accept   = s_tvalid && adv_a;

    logic signed [SMP_W-1:0] sample;
    logic signed [SMP_W-1:0] old_sample;

    assign sample = s_tdata[SMP_W-1:0];

    eod_window u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (accept),
        .wr_data    (sample),
        .old_sample (old_sample)
    );

    logic [HOP_W-1:0] hop_count_reg;
    logic [HOP_W:0]   hop_inc;
    logic             hop_hit;

    assign hop_inc = {1'b0, hop_count_reg} + 1'b1;
    assign hop_hit = (hop_inc >= {1'b0, hop_len_reg});

    stage_t stage_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hop_count_reg <= '0;
            a_valid_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (accept) begin
                hop_count_reg <= hop_hit ? '0 : hop_inc[HOP_W-1:0];
            end
            if (adv_a) begin
                a_valid_reg <= s_tvalid;
            end
            if (adv_b) begin
                m_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stage_reg.hop    <= hop_hit;
            stage_reg.new_sq <= square_of(sample);
            stage_reg.old_sq <= square_of(old_sample);
        end
    end

    result_t result;

    eod_eval u_eval (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (adv_b && a_valid_reg),
        .stage            (stage_reg),
        .energy_threshold (thr_reg),
        .refractory_hops  (refr_hops_reg),
        .pulse_hops       (pulse_hops_reg),
        .result           (result)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = result.hop_done;
    assign m_tdata  = {7'd0, result.marker_pulse, result.mean_energy, result.onset};

endmodule

`default_nettype wire
